/* hdl/sris_pkg.sv */
// ----------------------------------------------------------------------------
// sris_pkg
// Shared types, codes and compare functions for the record sorter.
// ----------------------------------------------------------------------------
package sris_pkg;

  typedef struct packed {
    logic [7:0]  units;
    logic [7:0]  grade;
    logic [63:0] description;
    logic [63:0] term;
  } rec_t;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_SORT   = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] KEY_UNITS = 2'd0;
  localparam logic [1:0] KEY_GRADE = 2'd1;
  localparam logic [1:0] KEY_DESC  = 2'd2;
  localparam logic [1:0] KEY_TERM  = 2'd3;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  localparam logic [2:0] RD_ZERO = 3'd0;
  localparam logic [2:0] RD_I    = 3'd1;
  localparam logic [2:0] RD_J    = 3'd2;
  localparam logic [2:0] RD_KN   = 3'd3;
  localparam logic [2:0] RD_JM1  = 3'd4;

  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       append;
    logic       clear;
    logic       i_set1;
    logic       i_inc;
    logic       k_clr;
    logic       k_inc;
    logic       j_from_i;
    logic       j_dec;
    logic       j_clr;
    logic       j_inc;
    logic [2:0] rd_sel;
    logic       rd_en;
    logic       hold_ld;
    logic       wr_hold;
    logic       wr_shift;
    logic       out_ld;
    logic       out_rec;
    logic [1:0] out_status;
    logic       out_last;
  } sris_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic i_done;
    logic k_last;
    logic j_eq_k;
    logic d_last;
    logic below;
  } sris_sts_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) ? c - 8'd32 : c;
  endfunction

  // keep bytes up to the first zero and within nch characters
  function automatic logic [63:0] cut_text(input logic [63:0] w, input logic [3:0] nch);
    logic [63:0] r;
    logic        alive;
    r     = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      alive = alive && (w[8*b +: 8] != 8'd0) && (4'(b) < nch);
      if (alive) r[8*b +: 8] = w[8*b +: 8];
    end
    return r;
  endfunction

  // first character most significant, folded to lower case
  function automatic logic [63:0] text_key(input logic [63:0] w);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) r[63-8*b -: 8] = fold_lower(w[8*b +: 8]);
    return r;
  endfunction

  function automatic logic six_long(input logic [63:0] t);
    return (t[47:40] != 8'd0) && (t[55:48] == 8'd0);
  endfunction

  function automatic logic starts(input logic [63:0] t, input logic [7:0] c0,
                                  input logic [7:0] c1);
    return (fold_lower(t[7:0]) == c0) && (fold_lower(t[15:8]) == c1);
  endfunction

  function automatic logic signed [14:0] term_year(input logic [63:0] t);
    logic [7:0]  c;
    logic        begun;
    logic        stop;
    logic        neg;
    logic [13:0] v;
    begun = 1'b0;
    stop  = 1'b0;
    neg   = 1'b0;
    v     = '0;
    for (int p = 2; p < 6; p++) begin
      c = t[8*p +: 8];
      if (!stop) begin
        if (!begun && (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
          begun = 1'b0;
        end else if (!begun && (c == CH_PLUS || c == CH_MINUS)) begin
          neg   = (c == CH_MINUS);
          begun = 1'b1;
        end else if (c >= CH_0 && c <= CH_9) begin
          v     = 14'(v * 14'd10) + 14'(c - CH_0);
          begun = 1'b1;
        end else begin
          stop = 1'b1;
        end
      end
    end
    return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  // true when record a must go in front of record b
  function automatic logic rec_below(input logic [1:0] key, input rec_t a, input rec_t b);
    logic                desc_lt;
    logic signed [14:0]  ya;
    logic signed [14:0]  yb;
    logic                r;
    desc_lt = text_key(a.description) < text_key(b.description);
    ya      = term_year(a.term);
    yb      = term_year(b.term);
    case (key)
      KEY_UNITS: r = a.units < b.units;
      KEY_GRADE: r = fold_upper(a.grade) < fold_upper(b.grade);
      KEY_DESC:  r = desc_lt;
      default: begin
        if (!six_long(a.term) || !six_long(b.term) ||
            text_key(a.term) == text_key(b.term)) begin
          r = desc_lt;
        end else if (ya != yb) begin
          r = ya < yb;
        end else if (starts(a.term, CH_S, CH_P)) begin
          r = 1'b1;
        end else if (starts(a.term, CH_S, CH_U)) begin
          r = !starts(b.term, CH_S, CH_P);
        end else begin
          r = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

/* hdl/stable_record_insertion_sorter_unit.sv */
// ----------------------------------------------------------------------------
// stable_record_insertion_sorter_unit
// Record store with append, stable insertion sort, dump and clear commands.
// ----------------------------------------------------------------------------
// Usage: one request on the in_ channel carries a command and, for append,
// the record fields. in_stall stays high while a command is in progress.
// Append, sort and clear give one result each; dump gives one result per
// held record in store order, or a single result with status empty.
// out_last marks the final result of a request.
// Sequencing: append and clear pass through the emit state, which loads
// the result register once the receiver has room. Dump reads each record
// in a read state and then loads it in the emit state. Sort runs one
// record at a time through a single store read port: for record i, it
// loads the record, compares it with earlier records in turn, moves
// records up one at a time and drops record i into place.
// Reset empties the store; the store contents are not cleared.
// A stalled result holds in the output register; the sequencer waits for
// it to drain before loading the next result.
// ----------------------------------------------------------------------------
module stable_record_insertion_sorter_unit import sris_pkg::*; #(
  parameter int MAX_RECORDS = 32,
  parameter int TEXT_CHARS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_sort_key,
  input  logic [7:0]  in_units,
  input  logic [7:0]  in_grade,
  input  logic [63:0] in_description,
  input  logic [63:0] in_term,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_units,
  output logic [7:0]  out_grade,
  output logic [63:0] out_description,
  output logic [63:0] out_term,
  output logic [6:0]  out_record_total,
  output logic        out_last
);

  sris_cmd_t cmd;
  sris_sts_t sts;

  sris_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  sris_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .TEXT_CHARS  (TEXT_CHARS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sort_key      (in_sort_key),
    .in_units         (in_units),
    .in_grade         (in_grade),
    .in_description   (in_description),
    .in_term          (in_term),
    .out_status       (out_status),
    .out_units        (out_units),
    .out_grade        (out_grade),
    .out_description  (out_description),
    .out_term         (out_term),
    .out_record_total (out_record_total),
    .out_last         (out_last)
  );

endmodule

/* hdl/sris_ctrl.sv */
// ----------------------------------------------------------------------------
// sris_ctrl
// Command sequencer: append, insertion sort passes, dump and clear.
// ----------------------------------------------------------------------------
module sris_ctrl import sris_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [1:0] in_command,
  output logic      out_valid,
  input  logic      out_stall,
  output sris_cmd_t cmd,
  input  sris_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EMIT = 3'd1;
  localparam logic [2:0] S_SNXT = 3'd2;
  localparam logic [2:0] S_SLDI = 3'd3;
  localparam logic [2:0] S_SCMP = 3'd4;
  localparam logic [2:0] S_SHRD = 3'd5;
  localparam logic [2:0] S_SHWR = 3'd6;
  localparam logic [2:0] S_DRD  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic       dump_r, dump_nxt;
  logic       oval_r, oval_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = oval_r;
  assign out_free  = !oval_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    stat_nxt  = stat_r;
    dump_nxt  = dump_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          dump_nxt = 1'b0;
          stat_nxt = STS_OK;
          case (in_command)
            CMD_APPEND: begin
              if (sts.full) stat_nxt = STS_FULL;
              else cmd.append = 1'b1;
              state_nxt = S_EMIT;
            end
            CMD_SORT: begin
              cmd.i_set1 = 1'b1;
              state_nxt  = S_SNXT;
            end
            CMD_DUMP: begin
              if (sts.empty) begin
                stat_nxt  = STS_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                cmd.j_clr = 1'b1;
                dump_nxt  = 1'b1;
                state_nxt = S_DRD;
              end
            end
            default: begin
              cmd.clear = 1'b1;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_rec    = dump_r;
          cmd.out_status = stat_r;
          cmd.out_last   = !dump_r || sts.d_last;
          if (dump_r && !sts.d_last) begin
            cmd.j_inc = 1'b1;
            state_nxt = S_DRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DRD: begin
        cmd.rd_sel = RD_J;
        cmd.rd_en  = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_SNXT: begin
        if (sts.i_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.rd_sel = RD_I;
          cmd.rd_en  = 1'b1;
          state_nxt  = S_SLDI;
        end
      end
      S_SLDI: begin
        cmd.hold_ld = 1'b1;
        cmd.k_clr   = 1'b1;
        cmd.rd_sel  = RD_ZERO;
        cmd.rd_en   = 1'b1;
        state_nxt   = S_SCMP;
      end
      S_SCMP: begin
        if (sts.below) begin
          cmd.j_from_i = 1'b1;
          state_nxt    = S_SHRD;
        end else if (sts.k_last) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_SNXT;
        end else begin
          cmd.k_inc  = 1'b1;
          cmd.rd_sel = RD_KN;
          cmd.rd_en  = 1'b1;
        end
      end
      S_SHRD: begin
        if (sts.j_eq_k) begin
          cmd.wr_hold = 1'b1;
          cmd.i_inc   = 1'b1;
          state_nxt   = S_SNXT;
        end else begin
          cmd.rd_sel = RD_JM1;
          cmd.rd_en  = 1'b1;
          state_nxt  = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        cmd.j_dec    = 1'b1;
        state_nxt    = S_SHRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    oval_nxt = oval_r;
    if (cmd.out_ld) oval_nxt = 1'b1;
    else if (!out_stall) oval_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stat_r  <= STS_OK;
      dump_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
      dump_r  <= dump_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

/* hdl/sris_dp.sv */
// ----------------------------------------------------------------------------
// sris_dp
// Record store, index counters, key comparator and result register.
// ----------------------------------------------------------------------------
module sris_dp import sris_pkg::*; #(
  parameter int MAX_RECORDS = 32,
  parameter int TEXT_CHARS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sris_cmd_t   cmd,
  output sris_sts_t   sts,
  input  logic [1:0]  in_sort_key,
  input  logic [7:0]  in_units,
  input  logic [7:0]  in_grade,
  input  logic [63:0] in_description,
  input  logic [63:0] in_term,
  output logic [1:0]  out_status,
  output logic [7:0]  out_units,
  output logic [7:0]  out_grade,
  output logic [63:0] out_description,
  output logic [63:0] out_term,
  output logic [6:0]  out_record_total,
  output logic        out_last
);

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  rec_t          mem [MAX_RECORDS];
  rec_t          rdata_r;
  rec_t          hold_r;
  rec_t          new_rec;
  rec_t          wdata;
  logic [IW-1:0] waddr;
  logic          wen;
  logic [CW-1:0] raddr;
  logic [CW-1:0] count_r, i_r, k_r, j_r;
  logic [1:0]    key_r;

  assign new_rec = '{units: in_units, grade: in_grade,
                     description: cut_text(in_description, 4'(TEXT_CHARS)),
                     term: cut_text(in_term, 4'(TEXT_CHARS))};

  always_comb begin
    case (cmd.rd_sel)
      RD_I:    raddr = i_r;
      RD_J:    raddr = j_r;
      RD_KN:   raddr = k_r + CW'(1);
      RD_JM1:  raddr = j_r - CW'(1);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    wen   = cmd.append | cmd.wr_hold | cmd.wr_shift;
    waddr = j_r[IW-1:0];
    wdata = rdata_r;
    if (cmd.append) begin
      waddr = count_r[IW-1:0];
      wdata = new_rec;
    end else if (cmd.wr_hold) begin
      waddr = k_r[IW-1:0];
      wdata = hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata_r <= mem[raddr[IW-1:0]];
    if (cmd.hold_ld) hold_r <= rdata_r;
    if (cmd.take) key_r <= in_sort_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      i_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
    end else begin
      if (cmd.clear) count_r <= '0;
      else if (cmd.append) count_r <= count_r + CW'(1);
      if (cmd.i_set1) i_r <= CW'(1);
      else if (cmd.i_inc) i_r <= i_r + CW'(1);
      if (cmd.k_clr) k_r <= '0;
      else if (cmd.k_inc) k_r <= k_r + CW'(1);
      if (cmd.j_from_i) j_r <= i_r;
      else if (cmd.j_dec) j_r <= j_r - CW'(1);
      else if (cmd.j_clr) j_r <= '0;
      else if (cmd.j_inc) j_r <= j_r + CW'(1);
    end
  end

  assign sts.full   = (count_r == CW'(MAX_RECORDS));
  assign sts.empty  = (count_r == '0);
  assign sts.i_done = (i_r >= count_r);
  assign sts.k_last = (k_r + CW'(1) == i_r);
  assign sts.j_eq_k = (j_r == k_r);
  assign sts.d_last = (j_r + CW'(1) == count_r);
  assign sts.below  = rec_below(key_r, hold_r, rdata_r);

  // result register, loaded once the receiver has room
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status       <= cmd.out_status;
      out_units        <= cmd.out_rec ? rdata_r.units : 8'd0;
      out_grade        <= cmd.out_rec ? rdata_r.grade : 8'd0;
      out_description  <= cmd.out_rec ? rdata_r.description : 64'd0;
      out_term         <= cmd.out_rec ? rdata_r.term : 64'd0;
      out_record_total <= 7'(count_r);
      out_last         <= cmd.out_last;
    end
  end

endmodule

/* hdl/sris_chk.sv */
// ----------------------------------------------------------------------------
// sris_chk
// Port-level checks for the record sorter, bound to the top level.
// ----------------------------------------------------------------------------
module sris_chk import sris_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [7:0]  out_units,
  input logic [7:0]  out_grade,
  input logic [63:0] out_description,
  input logic [63:0] out_term,
  input logic [6:0]  out_record_total,
  input logic        out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_term) && $stable(out_last))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_last)
    else $error("error status on non-final result");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_EMPTY |-> out_record_total == 7'd0)
    else $error("empty status with records held");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("request taken during dump");

  a_norec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |->
      out_units == 8'd0 && out_grade == 8'd0 && out_description == 64'd0)
    else $error("record data on error result");

endmodule

bind stable_record_insertion_sorter_unit sris_chk u_sris_chk (.*);

/* tb/stable_record_insertion_sorter_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_record_insertion_sorter_unit_tb
// Drives append, sort, dump and clear requests with random gaps and output
// stalls, predicts every result from a local model of the record store and
// compares each result field by field in order of arrival.
// ----------------------------------------------------------------------------
module stable_record_insertion_sorter_unit_tb;
  import sris_pkg::*;

  localparam int NREC = 32;
  localparam int MAX_CYCLES = 2000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  key;
    logic [7:0]  units;
    logic [7:0]  grade;
    logic [63:0] desc;
    logic [63:0] term;
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  units;
    logic [7:0]  grade;
    logic [63:0] desc;
    logic [63:0] term;
    logic [6:0]  total;
    logic        last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = '0;
  logic [1:0] in_sort_key = '0;
  logic [7:0] in_units = '0;
  logic [7:0] in_grade = '0;
  logic [63:0] in_description = '0;
  logic [63:0] in_term = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_units;
  logic [7:0] out_grade;
  logic [63:0] out_description;
  logic [63:0] out_term;
  logic [6:0] out_record_total;
  logic out_last;

  stable_record_insertion_sorter_unit DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  req_t pending_reqs[$];
  res_t expected_results[$];
  rec_t shelf[NREC];
  int   shelf_count = 0;
  int   mismatches = 0;
  int   cycles = 0;

  // ---- predictor ----
  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [63:0] trim_text(logic [63:0] w);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (w[8*b +: 8] == 8'd0) break;
      r[8*b +: 8] = w[8*b +: 8];
    end
    return r;
  endfunction

  function automatic int text_length(logic [63:0] w);
    int n;
    n = 0;
    while (n < 8 && w[8*n +: 8] != 8'd0) n++;
    return n;
  endfunction

  function automatic int text_order(logic [63:0] a, logic [63:0] b);
    logic [7:0] ca, cb;
    for (int k = 0; k < 8; k++) begin
      ca = to_lower(a[8*k +: 8]);
      cb = to_lower(b[8*k +: 8]);
      if (ca != cb) return (ca < cb) ? -1 : 1;
      if (ca == 8'd0) return 0;
    end
    return 0;
  endfunction

  function automatic int year_of(logic [63:0] t);
    int k, v;
    bit neg;
    logic [7:0] c;
    k = 2; v = 0; neg = 0;
    while (k < 6) begin
      c = t[8*k +: 8];
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) k++;
      else break;
    end
    if (k < 6 && (t[8*k +: 8] == "+" || t[8*k +: 8] == "-")) begin
      neg = t[8*k +: 8] == "-";
      k++;
    end
    while (k < 6) begin
      c = t[8*k +: 8];
      if (c < "0" || c > "9") break;
      v = v * 10 + int'(c - "0");
      k++;
    end
    return neg ? -v : v;
  endfunction

  function automatic bit season_is(logic [63:0] t, logic [7:0] c0, logic [7:0] c1);
    return to_lower(t[7:0]) == c0 && to_lower(t[15:8]) == c1;
  endfunction

  function automatic bit goes_first(logic [1:0] key, rec_t a, rec_t b);
    int ya, yb;
    case (key)
      KEY_UNITS: return a.units < b.units;
      KEY_GRADE: return to_upper(a.grade) < to_upper(b.grade);
      KEY_DESC:  return text_order(a.description, b.description) < 0;
      default: begin
        if (text_length(a.term) != 6 || text_length(b.term) != 6 ||
            text_order(a.term, b.term) == 0)
          return text_order(a.description, b.description) < 0;
        ya = year_of(a.term);
        yb = year_of(b.term);
        if (ya != yb) return ya < yb;
        if (season_is(a.term, "s", "p")) return 1'b1;
        if (season_is(a.term, "s", "u")) return !season_is(b.term, "s", "p");
        return 1'b0;
      end
    endcase
  endfunction

  function automatic res_t blank_result(logic [1:0] st);
    res_t r;
    r.status = st; r.units = '0; r.grade = '0; r.desc = '0; r.term = '0;
    r.total = 7'(shelf_count); r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_request(req_t q);
    int k;
    rec_t hold;
    res_t r;
    case (q.cmd)
      CMD_APPEND: begin
        if (shelf_count >= NREC) begin
          expected_results.push_back(blank_result(STS_FULL));
        end else begin
          shelf[shelf_count] = '{q.units, q.grade, trim_text(q.desc), trim_text(q.term)};
          shelf_count++;
          expected_results.push_back(blank_result(STS_OK));
        end
      end
      CMD_SORT: begin
        for (int i = 1; i < shelf_count; i++) begin
          for (k = 0; k < i; k++) if (goes_first(q.key, shelf[i], shelf[k])) break;
          if (k == i) continue;
          hold = shelf[i];
          for (int j = i; j > k; j--) shelf[j] = shelf[j-1];
          shelf[k] = hold;
        end
        expected_results.push_back(blank_result(STS_OK));
      end
      CMD_DUMP: begin
        if (shelf_count == 0) expected_results.push_back(blank_result(STS_EMPTY));
        for (int i = 0; i < shelf_count; i++) begin
          r = blank_result(STS_OK);
          r.units = shelf[i].units; r.grade = shelf[i].grade;
          r.desc = shelf[i].description; r.term = shelf[i].term;
          r.last = (i == shelf_count - 1);
          expected_results.push_back(r);
        end
      end
      default: begin
        shelf_count = 0;
        expected_results.push_back(blank_result(STS_OK));
      end
    endcase
  endtask

  // ---- stimulus ----
  function automatic logic [63:0] random_text();
    logic [63:0] w;
    int n;
    w = '0;
    n = $urandom_range(0, 8);
    for (int b = 0; b < n; b++) begin
      case ($urandom_range(0, 3))
        0: w[8*b +: 8] = 8'($urandom_range("A", "Z"));
        1: w[8*b +: 8] = 8'($urandom_range("a", "z"));
        2: w[8*b +: 8] = 8'($urandom_range(1, 255));
        default: w[8*b +: 8] = 8'($urandom_range("0", "9"));
      endcase
    end
    if ($urandom_range(0, 9) == 0) w = {$urandom, $urandom};
    return w;
  endfunction

  function automatic logic [63:0] random_term();
    logic [63:0] t;
    logic [7:0] s0, s1;
    if ($urandom_range(0, 4) == 0) return random_text();
    case ($urandom_range(0, 3))
      0: begin s0 = "S"; s1 = "P"; end
      1: begin s0 = "s"; s1 = "u"; end
      2: begin s0 = "F"; s1 = "A"; end
      default: begin s0 = "w"; s1 = "I"; end
    endcase
    t = '0;
    t[7:0] = s0; t[15:8] = s1;
    for (int b = 2; b < 6; b++) t[8*b +: 8] = 8'($urandom_range("0", "9"));
    if ($urandom_range(0, 7) == 0) t[23:16] = " ";
    if ($urandom_range(0, 7) == 0) t[31:24] = "-";
    t[23:16] = ($urandom_range(0, 1)) ? t[23:16] : "2";
    return t;
  endfunction

  function automatic req_t make_req(logic [1:0] cmd, logic [1:0] key,
                                    logic [7:0] u, logic [7:0] g,
                                    logic [63:0] d, logic [63:0] t);
    req_t q;
    q.cmd = cmd; q.key = key; q.units = u; q.grade = g; q.desc = d; q.term = t;
    return q;
  endfunction

  function automatic req_t random_append();
    return make_req(CMD_APPEND, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range("A", "F") +
                                                     32 * $urandom_range(0, 1)),
                    random_text(), random_term());
  endfunction

  initial begin
    int n_random;
    pending_reqs.push_back(make_req(CMD_DUMP, KEY_TERM, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(CMD_SORT, KEY_UNITS, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(CMD_APPEND, KEY_UNITS, 8'hff, 8'hff, '1, '1));
    pending_reqs.push_back(make_req(CMD_APPEND, KEY_GRADE, 8'h00, "b", "abc", "SP2020"));
    pending_reqs.push_back(make_req(CMD_APPEND, KEY_DESC, 8'h00, "B",
                                    64'h4142_4300_4445_4647, "su2020"));
    pending_reqs.push_back(make_req(CMD_APPEND, KEY_TERM, 8'h10, 8'h00, "ABC", "FA2020"));
    pending_reqs.push_back(make_req(CMD_APPEND, KEY_UNITS, 8'h10, "z", "zz", "Fa -12"));
    pending_reqs.push_back(make_req(CMD_APPEND, KEY_UNITS, 8'h01, "Z", "aa", "SP2019"));
    pending_reqs.push_back(make_req(CMD_APPEND, KEY_UNITS, 8'h02, "a", "Ab", "sp+019"));
    pending_reqs.push_back(make_req(CMD_APPEND, KEY_UNITS, 8'h03, "c", "ab", "SU20"));
    for (int k = 0; k < 4; k++) begin
      pending_reqs.push_back(make_req(CMD_SORT, 2'(k), '0, '0, '0, '0));
      pending_reqs.push_back(make_req(CMD_DUMP, 2'(k), '0, '0, '0, '0));
    end
    pending_reqs.push_back(make_req(CMD_CLEAR, KEY_GRADE, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(CMD_DUMP, KEY_UNITS, '0, '0, '0, '0));
    // fill past capacity to hit the full case
    for (int k = 0; k < NREC + 2; k++) pending_reqs.push_back(random_append());
    pending_reqs.push_back(make_req(CMD_SORT, KEY_TERM, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(CMD_DUMP, KEY_TERM, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(CMD_CLEAR, KEY_UNITS, '0, '0, '0, '0));
    n_random = 0;
    while (n_random < 95) begin
      int len;
      len = $urandom_range(0, 12);
      for (int k = 0; k < len; k++) pending_reqs.push_back(random_append());
      n_random += len;
      for (int k = $urandom_range(0, 2); k > 0; k--)
        pending_reqs.push_back(make_req(CMD_SORT, 2'($urandom_range(0, 3)), '0, '0, '0, '0));
      pending_reqs.push_back(make_req(CMD_DUMP, 2'($urandom_range(0, 3)),
                                      8'($urandom), 8'($urandom), '0, '0));
      if ($urandom_range(0, 2) == 0)
        pending_reqs.push_back(make_req(CMD_CLEAR, 2'($urandom_range(0, 3)),
                                        '0, '0, '0, '0));
      n_random += 3;
    end
  end

  // ---- driver ----
  int gap = 0;
  logic in_stall_seen = 1'b1;
  always @(posedge clk) in_stall_seen <= in_stall;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_seen) begin
        // accepted on the last rising edge
        in_valid <= 1'b0;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      end else if (!in_valid && pending_reqs.size() > 0) begin
        if (gap > 0) gap--;
        else begin
          req_t q;
          q = pending_reqs.pop_front();
          predict_request(q);
          in_command <= q.cmd; in_sort_key <= q.key; in_units <= q.units;
          in_grade <= q.grade; in_description <= q.desc; in_term <= q.term;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // ---- monitor ----
  int stall_left = 0;
  always @(posedge clk) begin
    res_t e;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", out_status);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status || out_units !== e.units || out_grade !== e.grade ||
            out_description !== e.desc || out_term !== e.term ||
            out_record_total !== e.total || out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %h %h %h %h %0d %0d got %0d %h %h %h %h %0d %0d",
                     e.status, e.units, e.grade, e.desc, e.term, e.total, e.last,
                     out_status, out_units, out_grade, out_description, out_term,
                     out_record_total, out_last);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (3000) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    wait (cycles >= MAX_CYCLES);
    $display("status: fail");
    $finish;
  end
endmodule

/* stable_record_insertion_sorter_unit.f */
hdl/sris_pkg.sv
hdl/sris_ctrl.sv
hdl/sris_dp.sv
hdl/stable_record_insertion_sorter_unit.sv
hdl/sris_chk.sv
tb/stable_record_insertion_sorter_unit_tb.sv
